>>> rtl/dct_pkg.sv
// shared constants, action codes and types for the connectivity tracker
// no dependencies; used by the tracker top level, the tally unit and the bench
package dct_pkg;

   localparam int NODE_W             = 10;
   localparam int NODE_SPAN          = 1 << NODE_W;
   localparam int NODE_SLOTS_DEFAULT = 1024;
   localparam int TALLY_W            = 16;
   localparam int RED_K_W            = $clog2(NODE_W);

   localparam logic [NODE_W-1:0]  NODE_COUNT_RESET = NODE_W'(1023);
   localparam logic [TALLY_W-1:0] TALLY_MAX        = '1;

   localparam logic [1:0] ACT_CLEAR   = 2'd0;
   localparam logic [1:0] ACT_CONNECT = 2'd1;
   localparam logic [1:0] ACT_QUERY   = 2'd2;

   typedef struct packed {
      logic clr;
      logic inc_success;
      logic inc_failure;
   } tally_cmd_type;

   // highest shift k with slots << k still inside the node number range
   function automatic int red_top(int slots);
      int k;
      k = 0;
      for (int i = 0; i < NODE_W; i++) begin
         if ((slots << i) < NODE_SPAN) begin
            k = i;
         end
      end
      return k;
   endfunction

endpackage

>>> rtl/dct_tally.sv
// saturating success and failure tallies of the connectivity tracker
// depends on dct_pkg for widths and the command struct
module dct_tally (
   input  logic                         clock,
   input  logic                         reset,
   input  dct_pkg::tally_cmd_type       cmd,
   output logic [dct_pkg::TALLY_W-1:0]  success_total,
   output logic [dct_pkg::TALLY_W-1:0]  failure_total
);

   logic [dct_pkg::TALLY_W-1:0] success_ff, success_in;
   logic [dct_pkg::TALLY_W-1:0] failure_ff, failure_in;

   always_comb begin
      success_in = success_ff;
      failure_in = failure_ff;
      if (cmd.clr) begin
         success_in = '0;
         failure_in = '0;
      end else begin
         if (cmd.inc_success && success_ff != dct_pkg::TALLY_MAX) begin
            success_in = success_ff + 1'b1;
         end
         if (cmd.inc_failure && failure_ff != dct_pkg::TALLY_MAX) begin
            failure_in = failure_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         success_ff <= '0;
         failure_ff <= '0;
      end else begin
         success_ff <= success_in;
         failure_ff <= failure_in;
      end
   end

   assign success_total = success_ff;
   assign failure_total = failure_ff;

endmodule

>>> rtl/dynamic_connectivity_tracker.sv
// union-find connectivity tracker: parent table memory, find sequencer, result register
// depends on dct_pkg and dct_tally
//
//   channel  | direction | contents
//   req_     | in        | tuser: action; tdata: node_a, node_b
//   rsp_     | out       | tdata: connected, success_total, failure_total
//   csr_     | in        | write-only node_count
//
// when NODE_SLOTS is below 1024, each request first takes RED_TOP + 1 remainder steps; connect
// and query then walk both nodes to their roots with path halving, and each halving step is
// two dependent reads on the single memory port. clear resets entries 0 to
// min(node_count, NODE_SLOTS - 1); a self query or an unused action goes from dispatch to finish.
// after reset a clearing pass writes all NODE_SLOTS entries, one per cycle, with req_tready low.
// one item is in work at a time; a finished result waits in the output register while the
// next transfer is taken, and a second result stalls in its finish state.
module dynamic_connectivity_tracker #(
   parameter int NODE_SLOTS = dct_pkg::NODE_SLOTS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [23:0]               req_tdata,  // node_a, node_b, zero fill
   input  logic [1:0]                req_tuser,  // action
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [39:0]               rsp_tdata,  // connected, success_total, failure_total, fill
   input  logic                      csr_wen,
   input  logic [dct_pkg::NODE_W-1:0] csr_wdata
);

   localparam int SLOT_W   = $clog2(NODE_SLOTS);
   localparam int SLOT_MAX = NODE_SLOTS - 1;
   localparam bit NEED_RED = NODE_SLOTS < dct_pkg::NODE_SPAN;
   localparam int RED_TOP  = dct_pkg::red_top(NODE_SLOTS);

   localparam logic [3:0] ST_SWEEP    = 4'd0;
   localparam logic [3:0] ST_IDLE     = 4'd1;
   localparam logic [3:0] ST_REDUCE   = 4'd2;
   localparam logic [3:0] ST_DISPATCH = 4'd3;
   localparam logic [3:0] ST_FIND_P   = 4'd4;
   localparam logic [3:0] ST_FIND_GP  = 4'd5;
   localparam logic [3:0] ST_FINISH   = 4'd6;
   localparam logic [3:0] ST_EMIT     = 4'd7;

   localparam int NW = dct_pkg::NODE_W;
   localparam int TW = dct_pkg::TALLY_W;

   logic [3:0]                state_ff, state_in;
   logic [1:0]                action_ff, action_in;
   logic [NW-1:0]             a_ff, a_in;
   logic [NW-1:0]             b_ff, b_in;
   logic [dct_pkg::RED_K_W-1:0] red_k_ff, red_k_in;
   logic [SLOT_W-1:0]         x_ff, x_in;
   logic [SLOT_W-1:0]         ra_ff, ra_in;
   logic                      phase_ff, phase_in;
   logic                      linked_ff, linked_in;
   logic [SLOT_W-1:0]         sweep_idx_ff, sweep_idx_in;
   logic [SLOT_W-1:0]         sweep_last_ff, sweep_last_in;
   logic                      sweep_clr_ff, sweep_clr_in;
   logic [NW-1:0]             node_count_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [39:0]               rsp_data_ff, rsp_data_in;

   // parent table memory and its port
   logic [SLOT_W-1:0]         mem [NODE_SLOTS];
   logic                      mem_we, mem_re;
   logic [SLOT_W-1:0]         mem_wa, mem_wd, mem_ra;
   logic [SLOT_W-1:0]         rd_q_ff, fwd_data_ff, rd_data;
   logic                      fwd_ff;

   dct_pkg::tally_cmd_type    tally_cmd;
   logic [TW-1:0]             success_total, failure_total;

   logic [31:0]               red_div;
   logic [SLOT_W-1:0]         clamp_last;
   logic [SLOT_W-1:0]         slot_a, slot_b;

   assign red_div    = 32'(NODE_SLOTS) << red_k_ff;
   assign clamp_last = (32'(node_count_ff) > 32'(SLOT_MAX)) ? SLOT_W'(SLOT_MAX)
                                                            : SLOT_W'(node_count_ff);
   assign slot_a     = SLOT_W'(a_ff);
   assign slot_b     = SLOT_W'(b_ff);
   assign rd_data    = fwd_ff ? fwd_data_ff : rd_q_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_q_ff <= mem[mem_ra];
      end
      // same-entry read and write in one cycle returns the new value
      fwd_ff      <= mem_re && mem_we && (mem_wa == mem_ra);
      fwd_data_ff <= mem_wd;
   end

   always_comb begin
      state_in      = state_ff;
      action_in     = action_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      red_k_in      = red_k_ff;
      x_in          = x_ff;
      ra_in         = ra_ff;
      phase_in      = phase_ff;
      linked_in     = linked_ff;
      sweep_idx_in  = sweep_idx_ff;
      sweep_last_in = sweep_last_ff;
      sweep_clr_in  = sweep_clr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      mem_wa        = '0;
      mem_wd        = '0;
      mem_re        = 1'b0;
      mem_ra        = '0;
      tally_cmd     = '0;

      case (state_ff)
         ST_SWEEP: begin
            mem_we = 1'b1;
            mem_wa = sweep_idx_ff;
            mem_wd = sweep_idx_ff;
            sweep_idx_in = sweep_idx_ff + 1'b1;
            if (sweep_idx_ff == sweep_last_ff) begin
               state_in = sweep_clr_ff ? ST_FINISH : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               action_in = req_tuser;
               a_in      = req_tdata[NW-1:0];
               b_in      = req_tdata[2*NW-1:NW];
               red_k_in  = dct_pkg::RED_K_W'(RED_TOP);
               linked_in = 1'b0;
               state_in  = NEED_RED ? ST_REDUCE : ST_DISPATCH;
            end
         end
         ST_REDUCE: begin
            // one restoring remainder step on both node numbers
            if (32'(a_ff) >= red_div) begin
               a_in = a_ff - NW'(red_div);
            end
            if (32'(b_ff) >= red_div) begin
               b_in = b_ff - NW'(red_div);
            end
            red_k_in = red_k_ff - 1'b1;
            if (red_k_ff == '0) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (action_ff)
               dct_pkg::ACT_CLEAR: begin
                  sweep_idx_in  = '0;
                  sweep_last_in = clamp_last;
                  sweep_clr_in  = 1'b1;
                  state_in      = ST_SWEEP;
               end
               dct_pkg::ACT_CONNECT: begin
                  mem_re   = 1'b1;
                  mem_ra   = slot_a;
                  x_in     = slot_a;
                  phase_in = 1'b0;
                  state_in = ST_FIND_P;
               end
               dct_pkg::ACT_QUERY: begin
                  if (a_ff == b_ff) begin
                     linked_in = 1'b1;
                     state_in  = ST_FINISH;
                  end else begin
                     mem_re   = 1'b1;
                     mem_ra   = slot_a;
                     x_in     = slot_a;
                     phase_in = 1'b0;
                     state_in = ST_FIND_P;
                  end
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_FIND_P: begin
            if (rd_data != x_ff) begin
               mem_re   = 1'b1;
               mem_ra   = rd_data;
               state_in = ST_FIND_GP;
            end else if (!phase_ff) begin
               // first root found, walk from the second node
               ra_in    = x_ff;
               x_in     = slot_b;
               mem_re   = 1'b1;
               mem_ra   = slot_b;
               phase_in = 1'b1;
            end else begin
               if (action_ff == dct_pkg::ACT_CONNECT) begin
                  mem_we = ra_ff != x_ff;
                  mem_wa = ra_ff;
                  mem_wd = x_ff;
               end else begin
                  linked_in = ra_ff == x_ff;
               end
               state_in = ST_FINISH;
            end
         end
         ST_FIND_GP: begin
            // path halving: point x at its grandparent and continue from there
            mem_we   = 1'b1;
            mem_wa   = x_ff;
            mem_wd   = rd_data;
            mem_re   = 1'b1;
            mem_ra   = rd_data;
            x_in     = rd_data;
            state_in = ST_FIND_P;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               tally_cmd.clr         = action_ff == dct_pkg::ACT_CLEAR;
               tally_cmd.inc_success = (action_ff == dct_pkg::ACT_QUERY) && linked_ff;
               tally_cmd.inc_failure = (action_ff == dct_pkg::ACT_QUERY) && !linked_ff;
               sweep_clr_in          = 1'b0;
               state_in              = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = {7'd0, failure_total, success_total, linked_ff};
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         sweep_idx_ff  <= '0;
         sweep_last_ff <= SLOT_W'(SLOT_MAX);
         sweep_clr_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         node_count_ff <= dct_pkg::NODE_COUNT_RESET;
      end else begin
         state_ff      <= state_in;
         sweep_idx_ff  <= sweep_idx_in;
         sweep_last_ff <= sweep_last_in;
         sweep_clr_ff  <= sweep_clr_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wen) begin
            node_count_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      action_ff   <= action_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      red_k_ff    <= red_k_in;
      x_ff        <= x_in;
      ra_ff       <= ra_in;
      phase_ff    <= phase_in;
      linked_ff   <= linked_in;
      rsp_data_ff <= rsp_data_in;
   end

   dct_tally u_tally (
      .clock         (clock),
      .reset         (reset),
      .cmd           (tally_cmd),
      .success_total (success_total),
      .failure_total (failure_total)
   );

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> rtl/dct_checker.sv
// port-level checks on the connectivity tracker, bound to its top level
// no package needed; watches the handshakes and the result word of the tracker
module dct_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [39:0]                rsp_tdata
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // a linked answer is always counted in the success tally
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[16:1] != '0)
      else $error("linked result with zero success tally");

   // clearing pass after reset: no input taken, no result shown
   assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("activity right after reset");

   // one item in work at a time
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while an item is in work");

endmodule

bind dynamic_connectivity_tracker dct_checker u_dct_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> test/tb_dynamic_connectivity_tracker.sv
`timescale 1ns / 100ps
// self-checking bench for dynamic_connectivity_tracker: queue-fed driver, predictor, monitor
// depends on dct_pkg and the tracker rtl
module tb_dynamic_connectivity_tracker;

   localparam int          SLOTS      = dct_pkg::NODE_SLOTS_DEFAULT;
   localparam int          NODE_W     = dct_pkg::NODE_W;
   localparam int          TALLY_W    = dct_pkg::TALLY_W;
   localparam logic [1:0]  ACT_UNUSED = 2'd3;
   localparam int          LONG_STALL = 400;
   localparam int          IDLE_LIMIT = 20000;
   localparam int          BATCH      = 450;

   typedef struct packed {
      logic [1:0]        action;
      logic [NODE_W-1:0] node_a;
      logic [NODE_W-1:0] node_b;
   } action_item_type;

   typedef struct packed {
      logic               connected;
      logic [TALLY_W-1:0] success_total;
      logic [TALLY_W-1:0] failure_total;
   } tally_result_type;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [23:0]       req_tdata  = '0;  // node_a, node_b, zero fill
   logic [1:0]        req_tuser  = '0;  // action
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [39:0]       rsp_tdata;        // connected, success_total, failure_total, fill
   logic              csr_wen    = 1'b0;
   logic [NODE_W-1:0] csr_wdata  = '0;

   action_item_type  pending_actions[$];
   tally_result_type expected_tallies[$];
   action_item_type  offered_action;

   // shadow copy of the block state
   logic [NODE_W-1:0]  shadow_parent[SLOTS];
   logic [TALLY_W-1:0] success_tally = '0;
   logic [TALLY_W-1:0] failure_tally = '0;
   logic [NODE_W-1:0]  shadow_node_count = dct_pkg::NODE_COUNT_RESET;

   int send_gap_pct   = 0;
   int recv_gap_pct   = 0;
   int stall_requests = 0;
   int stall_served   = 0;
   int stall_left     = 0;
   int mismatch_count = 0;
   int result_index   = 0;
   int idle_cycles    = 0;

   dynamic_connectivity_tracker #(
      .NODE_SLOTS(SLOTS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // root lookup with path halving, bounded walk
   function automatic logic [NODE_W-1:0] root_of(input logic [NODE_W-1:0] start);
      logic [NODE_W-1:0] x;
      logic [NODE_W-1:0] gp;
      int steps;
      x = start;
      steps = 0;
      while (steps < SLOTS && shadow_parent[x] != x) begin
         gp = shadow_parent[shadow_parent[x]];
         shadow_parent[x] = gp;
         x = gp;
         steps++;
      end
      return x;
   endfunction

   function automatic tally_result_type track_action(input action_item_type item);
      tally_result_type r;
      logic linked;
      logic [NODE_W-1:0] ra;
      logic [NODE_W-1:0] rb;
      int last;
      linked = 1'b0;
      case (item.action)
         dct_pkg::ACT_CLEAR: begin
            last = shadow_node_count;
            if (last > SLOTS - 1) last = SLOTS - 1;
            for (int i = 0; i <= last; i++) shadow_parent[i] = NODE_W'(i);
            success_tally = '0;
            failure_tally = '0;
         end
         dct_pkg::ACT_CONNECT: begin
            ra = root_of(item.node_a);
            rb = root_of(item.node_b);
            if (ra != rb) shadow_parent[ra] = rb;
         end
         dct_pkg::ACT_QUERY: begin
            if (item.node_a == item.node_b) begin
               linked = 1'b1;
            end else begin
               ra = root_of(item.node_a);
               rb = root_of(item.node_b);
               linked = (ra == rb);
            end
            if (linked) begin
               if (success_tally != dct_pkg::TALLY_MAX) success_tally = success_tally + 1'b1;
            end else begin
               if (failure_tally != dct_pkg::TALLY_MAX) failure_tally = failure_tally + 1'b1;
            end
         end
         default: ;
      endcase
      r.connected     = linked;
      r.success_total = success_tally;
      r.failure_total = failure_tally;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int want_v, input int got_v);
      mismatch_count++;
      $display("mismatch at result %0d: %s expected %0d got %0d",
               result_index, what, want_v, got_v);
   endtask

   task automatic check_result(input logic [39:0] word);
      tally_result_type got;
      tally_result_type want;
      got.connected     = word[0];
      got.success_total = word[16:1];
      got.failure_total = word[32:17];
      if (expected_tallies.size() == 0) begin
         report_mismatch("unexpected result, connected", 0, got.connected);
      end else begin
         want = expected_tallies.pop_front();
         if (got.connected !== want.connected)
            report_mismatch("connected", want.connected, got.connected);
         if (got.success_total !== want.success_total)
            report_mismatch("success_total", want.success_total, got.success_total);
         if (got.failure_total !== want.failure_total)
            report_mismatch("failure_total", want.failure_total, got.failure_total);
      end
      result_index++;
   endtask

   // driver: predicts on each accepted transfer, then offers the next pending action
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_tallies = {expected_tallies, track_action(offered_action)};
         if (!req_tvalid || req_tready) begin
            if (pending_actions.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
               offered_action = pending_actions.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {4'b0, offered_action.node_b, offered_action.node_a};
               req_tuser  <= offered_action.action;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each result transfer and paces rsp_tready
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result(rsp_tdata);
         if (stall_served != stall_requests) begin
            stall_served <= stall_requests;
            stall_left   <= LONG_STALL;
            rsp_tready   <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_gap_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("dynamic_connectivity_tracker regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic queue_action(input logic [1:0] action, input int a, input int b);
      action_item_type item;
      item.action = action;
      item.node_a = NODE_W'(a);
      item.node_b = NODE_W'(b);
      pending_actions = {pending_actions, item};
   endtask

   task automatic drain();
      while (pending_actions.size() != 0 || req_tvalid || expected_tallies.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_node_count(input logic [NODE_W-1:0] value);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      shadow_node_count = value;
      @(posedge clock);
      csr_wen <= 1'b0;
      @(negedge clock);
   endtask

   function automatic int pick_node(input int base, input int span);
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, SLOTS - 1);
      return base + $urandom_range(0, span - 1);
   endfunction

   // mostly connects and queries inside a small window so sets actually merge
   task automatic random_actions(input int count, input int base, input int span);
      int r;
      int a;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         a = pick_node(base, span);
         if (r < 2)       queue_action(dct_pkg::ACT_CLEAR, pick_node(base, span), a);
         else if (r < 4)  queue_action(ACT_UNUSED, pick_node(base, span), a);
         else if (r < 48) queue_action(dct_pkg::ACT_CONNECT, a, pick_node(base, span));
         else if (r < 53) queue_action(dct_pkg::ACT_QUERY, a, a);
         else             queue_action(dct_pkg::ACT_QUERY, a, pick_node(base, span));
         if (i % 150 == 149) drain();
      end
      drain();
   endtask

   initial begin
      int nc;
      int base;
      for (int i = 0; i < SLOTS; i++) shadow_parent[i] = NODE_W'(i);
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // wait out the clearing pass after reset
      while (!req_tready) @(negedge clock);
      write_node_count(dct_pkg::NODE_COUNT_RESET);
      send_gap_pct = 15;
      recv_gap_pct = 58;

      // directed: extremes, self query, every action
      queue_action(dct_pkg::ACT_QUERY, 0, 0);
      queue_action(dct_pkg::ACT_QUERY, 0, 1023);
      queue_action(dct_pkg::ACT_CONNECT, 0, 1023);
      queue_action(dct_pkg::ACT_QUERY, 1023, 0);
      queue_action(dct_pkg::ACT_CONNECT, 1023, 1023);
      queue_action(dct_pkg::ACT_CONNECT, 5, 6);
      queue_action(dct_pkg::ACT_CONNECT, 6, 7);
      queue_action(dct_pkg::ACT_CONNECT, 7, 8);
      queue_action(dct_pkg::ACT_QUERY, 5, 8);
      queue_action(dct_pkg::ACT_QUERY, 8, 1023);
      queue_action(ACT_UNUSED, 1023, 1023);
      queue_action(dct_pkg::ACT_QUERY, 682, 341);
      queue_action(dct_pkg::ACT_CONNECT, 341, 682);
      queue_action(dct_pkg::ACT_QUERY, 682, 341);
      queue_action(dct_pkg::ACT_CLEAR, 0, 0);
      queue_action(dct_pkg::ACT_QUERY, 0, 1023);
      drain();

      // clear below the top: links of higher nodes survive
      write_node_count(2);
      queue_action(dct_pkg::ACT_CONNECT, 1, 3);
      queue_action(dct_pkg::ACT_CONNECT, 4, 0);
      queue_action(dct_pkg::ACT_CONNECT, 2, 5);
      queue_action(dct_pkg::ACT_CLEAR, 0, 0);
      queue_action(dct_pkg::ACT_QUERY, 3, 1);
      queue_action(dct_pkg::ACT_QUERY, 4, 0);
      drain();
      write_node_count(0);
      queue_action(dct_pkg::ACT_CONNECT, 0, 9);
      queue_action(dct_pkg::ACT_CONNECT, 10, 0);
      queue_action(dct_pkg::ACT_CLEAR, 0, 0);
      queue_action(dct_pkg::ACT_QUERY, 10, 0);
      queue_action(dct_pkg::ACT_QUERY, 9, 0);
      drain();

      // sender light, receiver heavy
      send_gap_pct = 15;
      recv_gap_pct = 58;
      nc = $urandom_range(64, 960);
      write_node_count(NODE_W'(nc));
      random_actions(BATCH, nc - 16, 48);

      // receiver holds off while the sender keeps offering
      stall_requests = stall_requests + 1;
      for (int i = 0; i < 24; i++)
         queue_action(i % 2 ? dct_pkg::ACT_QUERY : dct_pkg::ACT_CONNECT,
                      pick_node(nc - 16, 48), pick_node(nc - 16, 48));
      drain();

      // sender heavy, receiver light
      send_gap_pct = 58;
      recv_gap_pct = 15;
      write_node_count(0);
      random_actions(BATCH, 0, 24);

      send_gap_pct = 0;
      recv_gap_pct = 0;
      write_node_count(1);
      random_actions(BATCH, 0, 16);

      write_node_count(dct_pkg::NODE_COUNT_RESET);
      base = $urandom_range(0, 960);
      random_actions(BATCH, base, 64);

      // tallies across a clear
      queue_action(dct_pkg::ACT_QUERY, 0, 1);
      queue_action(dct_pkg::ACT_QUERY, 2, 2);
      queue_action(dct_pkg::ACT_CLEAR, 0, 0);
      queue_action(dct_pkg::ACT_QUERY, 3, 3);
      drain();

      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_tallies.size() == 0) begin
         $display("dynamic_connectivity_tracker regression: pass");
      end else begin
         $display("dynamic_connectivity_tracker regression: fail");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/dct_pkg.sv
rtl/dct_tally.sv
rtl/dynamic_connectivity_tracker.sv
rtl/dct_checker.sv
test/tb_dynamic_connectivity_tracker.sv
